// File: rtl/coh_pkg.sv
// shared constants, types and state codes for the seeded coherence stack search
package coh_pkg;

    localparam int MAX_NODES     = 4096;
    localparam int MAX_STATIONS  = 32;
    localparam int MAX_SAMPLES   = 4096;
    localparam int TOP_COUNT_DEF = 25;

    localparam int FUNC_W     = 2;
    localparam int NODE_W     = 12;
    localparam int STA_W      = 5;
    localparam int SAMP_W     = 12;
    localparam int NCNT_W     = 13;
    localparam int SCNT_W     = 6;
    localparam int KCNT_W     = 13;
    localparam int CFG_W      = 13;
    localparam int VAL_W      = 16;
    localparam int SUM_W      = 21;
    localparam int MAG_W      = 21;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int SCORE_W    = 15;
    localparam int SCORE_MAX  = 32767;
    localparam int SEED_DEPTH = 128;
    localparam int SEED_W     = 7;
    localparam int SEED_CNT_W = 8;
    localparam int BOUND_W    = 13;
    localparam int SHIFT_AW   = NODE_W + STA_W;
    localparam int TRACE_AW   = STA_W + SAMP_W;

    typedef enum logic [1:0] {
        FUNC_LOAD_SHIFT = 2'd0,
        FUNC_LOAD_TRACE = 2'd1,
        FUNC_COMPUTE    = 2'd2,
        FUNC_NONE       = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_NODE_COUNT    = 2'd0,
        CFG_STATION_COUNT = 2'd1,
        CFG_SAMPLE_COUNT  = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D_ROOT,
        ST_D_HALF,
        ST_D_SEED,
        ST_D_LAST,
        ST_C_SEED_RD,
        ST_C_SEED_WAIT,
        ST_ACC,
        ST_SCORE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_ROOT,
        SC_DIV
    } t_score_state;

    typedef struct packed {
        logic [NODE_W-1:0]  pos;
        logic [BOUND_W-1:0] left;
        logic [BOUND_W-1:0] right;
    } t_seed_entry;

    typedef struct packed {
        logic                     start;
        logic signed [SUM_W-1:0]  p_sum;
        logic signed [SUM_W-1:0]  s_sum;
        logic [SCNT_W-1:0]        ns;
    } t_score_req;

    typedef struct packed {
        logic               done;
        logic [SCORE_W-1:0] score;
    } t_score_rsp;

endpackage

// File: rtl/coh_in_if.sv
// input channel: one command word with valid and ready
interface coh_in_if import coh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [NODE_W-1:0]   node;
    logic [STA_W-1:0]    station;
    logic [SAMP_W-1:0]   sample_index;
    logic [SAMP_W-1:0]   p_travel_time;
    logic [SAMP_W-1:0]   s_travel_time;
    logic signed [VAL_W-1:0] p_value;
    logic signed [VAL_W-1:0] s_value;

    modport source (
        output valid, func, node, station, sample_index,
        output p_travel_time, s_travel_time, p_value, s_value,
        input  ready
    );
    modport sink (
        input  valid, func, node, station, sample_index,
        input  p_travel_time, s_travel_time, p_value, s_value,
        output ready
    );
endinterface

// File: rtl/coh_out_if.sv
// result channel: best score and node with valid and ready
interface coh_out_if import coh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] best_value;
    logic [NODE_W-1:0]  best_node;

    modport source (output valid, best_value, best_node, input ready);
    modport sink   (input valid, best_value, best_node, output ready);
endinterface

// File: rtl/coh_score.sv
// node score unit: product of sums, bit-serial square root, serial divide by station count
module coh_score import coh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_score_req i_req,
    output t_score_rsp o_rsp
);

    t_score_state r_state, n_state;
    logic [MAG_W-1:0]   r_a, n_a, r_b, n_b;
    logic [PROD_W-1:0]  r_x, n_x, r_r, n_r, r_bit, n_bit;
    logic [MAG_W-1:0]   r_quo, n_quo;
    logic [SCNT_W-1:0]  r_rem, n_rem;
    logic [4:0]         r_cnt, n_cnt;
    logic               r_done, n_done;
    logic [SCORE_W-1:0] r_score, n_score;

    logic [PROD_W-1:0]  w_prod;
    logic [PROD_W-1:0]  w_trial;
    logic [SCNT_W:0]    w_rem_sh;
    logic               w_ge;
    logic               w_same;

    assign w_prod   = r_a * r_b;
    assign w_trial  = r_r + r_bit;
    assign w_rem_sh = {r_rem, r_quo[MAG_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, i_req.ns};
    assign w_same   = (i_req.p_sum > 0 && i_req.s_sum > 0)
                   || (i_req.p_sum < 0 && i_req.s_sum < 0);

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_x     = r_x;
        n_r     = r_r;
        n_bit   = r_bit;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_score = r_score;
        unique case (r_state)
            SC_IDLE: begin
                if (i_req.start) begin
                    if (w_same) begin
                        n_a = i_req.p_sum[SUM_W-1] ? MAG_W'(~i_req.p_sum + 1'b1)
                                                   : MAG_W'(i_req.p_sum);
                        n_b = i_req.s_sum[SUM_W-1] ? MAG_W'(~i_req.s_sum + 1'b1)
                                                   : MAG_W'(i_req.s_sum);
                        n_state = SC_MUL;
                    end else begin
                        n_score = '0;
                        n_done  = 1'b1;
                    end
                end
            end
            SC_MUL: begin
                n_x     = w_prod;
                n_r     = '0;
                n_bit   = PROD_W'(1) << (PROD_W - 2);
                n_state = SC_ROOT;
            end
            SC_ROOT: begin
                if (r_x >= w_trial) begin
                    n_x = r_x - w_trial;
                    n_r = (r_r >> 1) + r_bit;
                end else begin
                    n_r = r_r >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_quo   = n_r[MAG_W-1:0];
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = SC_DIV;
                end
            end
            SC_DIV: begin
                n_rem = w_ge ? SCNT_W'(w_rem_sh - {1'b0, i_req.ns}) : w_rem_sh[SCNT_W-1:0];
                n_quo = {r_quo[MAG_W-2:0], w_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'(MAG_W - 1)) begin
                    n_score = (n_quo > MAG_W'(SCORE_MAX)) ? SCORE_W'(SCORE_MAX)
                                                          : n_quo[SCORE_W-1:0];
                    n_done  = 1'b1;
                    n_state = SC_IDLE;
                end
            end
            default: n_state = SC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_a     <= n_a;
        r_b     <= n_b;
        r_x     <= n_x;
        r_r     <= n_r;
        r_bit   <= n_bit;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_score <= n_score;
    end

    assign o_rsp = '{done: r_done, score: r_score};

endmodule

// File: rtl/seeded_coherence_stack_search_top.sv
// top level: stores, seed derivation and seeded grid search sequencer
//
// Use: words arrive on i_item. func load shift writes the P and S shifts of one
// node and station, func load trace writes one P and S sample of one station;
// both give no result. func compute scores grid nodes at time k and returns one
// word on o_result: the greatest score and its node.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data).
// For every node scored, a compute word reads each station through the shift
// and trace memories (one read port each), then runs the score unit (multiply,
// 21 root steps, 21 divide steps); every seed and every window first reads its
// seed table entry. With n nodes about 2*sqrt(n) seeds plus up to TOP_COUNT
// windows of 2*n/(4*sqrt(n)) + 1 nodes are scored: near 950 nodes at 4096
// nodes. One compute word is worked on at a time. After reset and after every
// node count write the seed table is rebuilt with i_item.ready low.
// A finished result waits in the output register while the receiver stalls;
// the next word is accepted meanwhile, a new result waits until it is taken.
module seeded_coherence_stack_search_top import coh_pkg::*; #(
    parameter int TOP_COUNT = TOP_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    coh_in_if.sink              i_item,
    coh_out_if.source           o_result,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int TOP_IW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
    localparam int FILL_W = $clog2(TOP_COUNT + 1);

    // memories
    logic [2*SAMP_W-1:0] shift_mem [MAX_NODES*MAX_STATIONS];
    logic [VAL_W-1:0]    p_trace_mem [MAX_STATIONS*MAX_SAMPLES];
    logic [VAL_W-1:0]    s_trace_mem [MAX_STATIONS*MAX_SAMPLES];
    t_seed_entry         seed_mem [SEED_DEPTH];

    logic [2*SAMP_W-1:0] r_sh_rdata;
    logic [VAL_W-1:0]    r_p_rdata, r_s_rdata;
    t_seed_entry         r_sd_rdata;

    t_state r_state, n_state;
    logic r_rederive, n_rederive;
    logic [NCNT_W-1:0] r_node_count;
    logic [SCNT_W-1:0] r_station_count;
    logic [KCNT_W-1:0] r_sample_count;

    logic [SEED_CNT_W-1:0] r_m, n_m, r_s, n_s;
    logic [BOUND_W-1:0]    r_wh, n_wh;
    logic [13:0]           r_whrem, n_whrem, r_rem, n_rem;
    logic [7:0]            r_den, n_den;
    logic [NODE_W-1:0]     r_q, n_q, r_prev, n_prev;
    logic [BOUND_W-1:0]    r_prev_left, n_prev_left;

    logic [SAMP_W-1:0] r_k, n_k;
    logic [NODE_W-1:0] r_node, n_node, r_i1, n_i1;
    logic              r_phase, n_phase;
    logic [TOP_IW-1:0] r_t, n_t;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [SCNT_W-1:0] r_j, n_j;
    logic              r_v1, n_v1, r_v2, n_v2, r_pok, n_pok, r_sok, n_sok;
    logic [STA_W-1:0]  r_j1, n_j1;
    logic signed [SUM_W-1:0] r_psum, n_psum, r_ssum, n_ssum;
    logic [SCORE_W-1:0] r_best, n_best;
    logic [NODE_W-1:0]  r_best_node, n_best_node;

    logic [SCORE_W-1:0] r_top_score [TOP_COUNT];
    logic [SEED_W-1:0]  r_top_seed  [TOP_COUNT];

    logic               r_out_valid;
    logic [SCORE_W-1:0] r_out_value;
    logic [NODE_W-1:0]  r_out_node;

    // control wires
    logic w_in_acc, w_load_out, w_issue, w_ins, w_sd_we, w_start;
    logic [SEED_W-1:0] w_sd_waddr, w_sd_raddr;
    t_seed_entry       w_sd_wdata;
    logic [NCNT_W-1:0] w_n, w_nm1;
    logic [SCNT_W-1:0] w_ns;
    logic [KCNT_W-1:0] w_nsamp;
    logic [8:0]        w_mp1;
    logic [17:0]       w_sq;
    logic [NODE_W:0]   w_mid_sum;
    logic [NODE_W-1:0] w_mid;
    logic [BOUND_W-1:0] w_raw_right, w_rc, w_right;
    logic [BOUND_W-1:0] w_c, w_lo, w_i0, w_i1a, w_i1;
    logic [BOUND_W:0]   w_hi;
    logic               w_lo_ok, w_t_last;
    logic [KCNT_W-1:0]  w_ip_p, w_ip_s;
    logic [SHIFT_AW-1:0] w_sh_raddr;
    logic [TRACE_AW-1:0] w_p_raddr, w_s_raddr;
    logic [TOP_COUNT-1:0] w_gt, w_prev_gt;
    t_score_req w_req;
    t_score_rsp w_rsp;

    assign i_item.ready = (r_state == ST_IDLE) && !r_rederive && !i_cfg_we;
    assign w_in_acc     = i_item.valid && i_item.ready;

    assign w_n     = (r_node_count == '0) ? NCNT_W'(1)
                   : (r_node_count > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : r_node_count;
    assign w_nm1   = w_n - 1'b1;
    assign w_ns    = (r_station_count == '0) ? SCNT_W'(1)
                   : (r_station_count > SCNT_W'(MAX_STATIONS)) ? SCNT_W'(MAX_STATIONS)
                   : r_station_count;
    assign w_nsamp = (r_sample_count == '0) ? KCNT_W'(1)
                   : (r_sample_count > KCNT_W'(MAX_SAMPLES)) ? KCNT_W'(MAX_SAMPLES)
                   : r_sample_count;

    // derivation arithmetic
    assign w_mp1       = {1'b0, r_m} + 1'b1;
    assign w_sq        = w_mp1 * w_mp1;
    assign w_mid_sum   = {1'b0, r_prev} + {1'b0, r_q};
    assign w_mid       = w_mid_sum[NODE_W:1];
    assign w_raw_right = (r_state == ST_D_LAST) ? w_nm1 : {1'b0, w_mid};
    assign w_rc        = (w_raw_right > w_nm1) ? w_nm1 : w_raw_right;
    assign w_right     = (w_rc < r_prev_left) ? r_prev_left : w_rc;

    // window bounds from the seed entry
    assign w_c     = {1'b0, r_sd_rdata.pos};
    assign w_lo_ok = w_c >= r_wh;
    assign w_lo    = w_c - r_wh;
    assign w_i0    = (!w_lo_ok || w_lo < r_sd_rdata.left) ? r_sd_rdata.left : w_lo;
    assign w_hi    = {1'b0, w_c} + {1'b0, r_wh};
    assign w_i1a   = (w_hi > {1'b0, r_sd_rdata.right}) ? r_sd_rdata.right : w_hi[BOUND_W-1:0];
    assign w_i1    = (w_i1a > w_nm1) ? w_nm1 : w_i1a;
    assign w_t_last = (FILL_W'(r_t) + 1'b1) == r_fill;

    // station read pipeline addresses
    assign w_sh_raddr = {r_node, r_j[STA_W-1:0]};
    assign w_ip_p     = {1'b0, r_sh_rdata[2*SAMP_W-1:SAMP_W]} + {1'b0, r_k};
    assign w_ip_s     = {1'b0, r_sh_rdata[SAMP_W-1:0]} + {1'b0, r_k};
    assign w_p_raddr  = {r_j1, w_ip_p[SAMP_W-1:0]};
    assign w_s_raddr  = {r_j1, w_ip_s[SAMP_W-1:0]};

    always_comb begin
        for (int i = 0; i < TOP_COUNT; i++) begin
            w_gt[i] = (FILL_W'(i) < r_fill) && (w_rsp.score > r_top_score[i]);
        end
        w_prev_gt[0] = 1'b0;
        for (int i = 1; i < TOP_COUNT; i++) begin
            w_prev_gt[i] = w_gt[i-1];
        end
    end

    assign w_req = '{start: w_start, p_sum: r_psum, s_sum: r_ssum, ns: w_ns};

    coh_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_rederive  = r_rederive;
        n_m         = r_m;
        n_s         = r_s;
        n_wh        = r_wh;
        n_whrem     = r_whrem;
        n_rem       = r_rem;
        n_den       = r_den;
        n_q         = r_q;
        n_prev      = r_prev;
        n_prev_left = r_prev_left;
        n_k         = r_k;
        n_node      = r_node;
        n_i1        = r_i1;
        n_phase     = r_phase;
        n_t         = r_t;
        n_fill      = r_fill;
        n_j         = r_j;
        n_psum      = r_psum;
        n_ssum      = r_ssum;
        n_best      = r_best;
        n_best_node = r_best_node;
        w_sd_we     = 1'b0;
        w_sd_waddr  = SEED_W'(r_s - 1'b1);
        w_sd_wdata  = '{pos: r_prev, left: r_prev_left, right: w_right};
        w_sd_raddr  = r_phase ? r_top_seed[r_t] : r_s[SEED_W-1:0];
        w_issue     = 1'b0;
        w_ins       = 1'b0;
        w_load_out  = 1'b0;
        w_start     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (r_rederive) begin
                    n_m     = SEED_CNT_W'(1);
                    n_state = ST_D_ROOT;
                end else if (w_in_acc && t_func'(i_item.func) == FUNC_COMPUTE) begin
                    n_k         = i_item.sample_index;
                    n_phase     = 1'b0;
                    n_s         = '0;
                    n_fill      = '0;
                    n_best      = '0;
                    n_best_node = '0;
                    n_state     = ST_C_SEED_RD;
                end
            end
            ST_D_ROOT: begin
                if (w_sq <= 18'({w_n, 2'b00})) begin
                    n_m = r_m + 1'b1;
                end else begin
                    n_den   = {r_m[SEED_W-1:0] - 1'b1, 1'b0};
                    n_rem   = 14'(r_m - 1'b1);
                    n_whrem = {1'b0, w_n} + 14'(r_m);
                    n_wh    = '0;
                    n_state = ST_D_HALF;
                end
            end
            ST_D_HALF: begin
                if (r_whrem >= 14'({r_m, 1'b0})) begin
                    n_whrem = r_whrem - 14'({r_m, 1'b0});
                    n_wh    = r_wh + 1'b1;
                end else begin
                    if (r_wh == '0) n_wh = BOUND_W'(1);
                    n_s         = '0;
                    n_q         = '0;
                    n_prev_left = '0;
                    n_state     = ST_D_SEED;
                end
            end
            ST_D_SEED: begin
                if (r_rem >= 14'(r_den)) begin
                    n_rem = r_rem - 14'(r_den);
                    n_q   = r_q + 1'b1;
                end else begin
                    if (r_s != '0) begin
                        w_sd_we     = 1'b1;
                        n_prev_left = {1'b0, w_mid} + 1'b1;
                    end
                    n_prev = r_q;
                    n_rem  = r_rem + 14'({w_nm1, 1'b0});
                    n_s    = r_s + 1'b1;
                    if ((r_s + 1'b1) == r_m) n_state = ST_D_LAST;
                end
            end
            ST_D_LAST: begin
                w_sd_we    = 1'b1;
                n_rederive = 1'b0;
                n_state    = ST_IDLE;
            end
            ST_C_SEED_RD: begin
                n_state = ST_C_SEED_WAIT;
            end
            ST_C_SEED_WAIT: begin
                n_j    = '0;
                n_psum = '0;
                n_ssum = '0;
                if (!r_phase) begin
                    n_node  = r_sd_rdata.pos;
                    n_state = ST_ACC;
                end else if (w_i0 > w_i1) begin
                    if (w_t_last) begin
                        n_state = ST_DONE;
                    end else begin
                        n_t     = r_t + 1'b1;
                        n_state = ST_C_SEED_RD;
                    end
                end else begin
                    n_node  = w_i0[NODE_W-1:0];
                    n_i1    = w_i1[NODE_W-1:0];
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (r_j < w_ns) begin
                    w_issue = 1'b1;
                    n_j     = r_j + 1'b1;
                end
                if (r_v2) begin
                    n_psum = r_psum + (r_pok ? SUM_W'(signed'(r_p_rdata)) : '0);
                    n_ssum = r_ssum + (r_sok ? SUM_W'(signed'(r_s_rdata)) : '0);
                end
                if (r_j == w_ns && !r_v1 && !r_v2) begin
                    w_start = 1'b1;
                    n_state = ST_SCORE;
                end
            end
            ST_SCORE: begin
                if (w_rsp.done) begin
                    if (w_rsp.score > r_best) begin
                        n_best      = w_rsp.score;
                        n_best_node = r_node;
                    end
                    if (!r_phase) begin
                        w_ins = 1'b1;
                        if (r_fill < FILL_W'(TOP_COUNT)) n_fill = r_fill + 1'b1;
                        if ((r_s + 1'b1) == r_m) begin
                            n_phase = 1'b1;
                            n_t     = '0;
                        end else begin
                            n_s = r_s + 1'b1;
                        end
                        n_state = ST_C_SEED_RD;
                    end else if (r_node != r_i1) begin
                        n_node  = r_node + 1'b1;
                        n_j     = '0;
                        n_psum  = '0;
                        n_ssum  = '0;
                        n_state = ST_ACC;
                    end else if (w_t_last) begin
                        n_state = ST_DONE;
                    end else begin
                        n_t     = r_t + 1'b1;
                        n_state = ST_C_SEED_RD;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (i_cfg_we && t_cfg_index'(i_cfg_index) == CFG_NODE_COUNT) begin
            n_rederive = 1'b1;
        end

        n_v1  = w_issue;
        n_j1  = r_j[STA_W-1:0];
        n_v2  = r_v1;
        n_pok = w_ip_p < w_nsamp;
        n_sok = w_ip_s < w_nsamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_rederive      <= 1'b1;
            r_node_count    <= NCNT_W'(MAX_NODES);
            r_station_count <= SCNT_W'(MAX_STATIONS);
            r_sample_count  <= KCNT_W'(MAX_SAMPLES);
            r_v1            <= 1'b0;
            r_v2            <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rederive <= n_rederive;
            r_v1       <= n_v1;
            r_v2       <= n_v2;
            r_out_valid <= w_load_out || (r_out_valid && !o_result.ready);
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_NODE_COUNT:    r_node_count    <= i_cfg_data;
                    CFG_STATION_COUNT: r_station_count <= i_cfg_data[SCNT_W-1:0];
                    CFG_SAMPLE_COUNT:  r_sample_count  <= i_cfg_data[KCNT_W-1:0];
                    CFG_UNUSED:        ;
                    default:           ;
                endcase
            end
        end
        r_m         <= n_m;
        r_s         <= n_s;
        r_wh        <= n_wh;
        r_whrem     <= n_whrem;
        r_rem       <= n_rem;
        r_den       <= n_den;
        r_q         <= n_q;
        r_prev      <= n_prev;
        r_prev_left <= n_prev_left;
        r_k         <= n_k;
        r_node      <= n_node;
        r_i1        <= n_i1;
        r_phase     <= n_phase;
        r_t         <= n_t;
        r_fill      <= n_fill;
        r_j         <= n_j;
        r_j1        <= n_j1;
        r_pok       <= n_pok;
        r_sok       <= n_sok;
        r_psum      <= n_psum;
        r_ssum      <= n_ssum;
        r_best      <= n_best;
        r_best_node <= n_best_node;
        if (w_load_out) begin
            r_out_value <= r_best;
            r_out_node  <= r_best_node;
        end
    end

    // sorted seed list, insertion in one step
    always_ff @(posedge i_clk) begin
        if (w_ins) begin
            for (int i = 0; i < TOP_COUNT; i++) begin
                if (w_prev_gt[i]) begin
                    r_top_score[i] <= r_top_score[i-1];
                    r_top_seed[i]  <= r_top_seed[i-1];
                end else if (w_gt[i] || FILL_W'(i) == r_fill) begin
                    r_top_score[i] <= w_rsp.score;
                    r_top_seed[i]  <= r_s[SEED_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && t_func'(i_item.func) == FUNC_LOAD_SHIFT) begin
            shift_mem[{i_item.node, i_item.station}] <= {i_item.p_travel_time,
                                                         i_item.s_travel_time};
        end
        r_sh_rdata <= shift_mem[w_sh_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && t_func'(i_item.func) == FUNC_LOAD_TRACE) begin
            p_trace_mem[{i_item.station, i_item.sample_index}] <= i_item.p_value;
        end
        r_p_rdata <= p_trace_mem[w_p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && t_func'(i_item.func) == FUNC_LOAD_TRACE) begin
            s_trace_mem[{i_item.station, i_item.sample_index}] <= i_item.s_value;
        end
        r_s_rdata <= s_trace_mem[w_s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_sd_we) begin
            seed_mem[w_sd_waddr] <= w_sd_wdata;
        end
        r_sd_rdata <= seed_mem[w_sd_raddr];
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.best_value = r_out_value;
    assign o_result.best_node  = r_out_node;

endmodule

// File: tb/sv/tb_top.sv
// testbench for the seeded coherence stack search: directed and random words against a predictor
module tb_top;
    import coh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_func             func;
        logic [NODE_W-1:0] node;
        logic [STA_W-1:0]  station;
        logic [SAMP_W-1:0] sample_index;
        logic [SAMP_W-1:0] p_tt;
        logic [SAMP_W-1:0] s_tt;
        logic [VAL_W-1:0]  p_val;
        logic [VAL_W-1:0]  s_val;
    } t_word;

    typedef struct {
        logic [SCORE_W-1:0] value;
        logic [NODE_W-1:0]  node;
    } t_best;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    coh_in_if  item_if();
    coh_out_if result_if();

    seeded_coherence_stack_search_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(item_if.sink), .o_result(result_if.source),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [SAMP_W-1:0] p_shift [MAX_NODES*MAX_STATIONS];
    logic [SAMP_W-1:0] s_shift [MAX_NODES*MAX_STATIONS];
    logic [VAL_W-1:0]  p_trace [MAX_STATIONS*MAX_SAMPLES];
    logic [VAL_W-1:0]  s_trace [MAX_STATIONS*MAX_SAMPLES];
    bit shift_loaded [MAX_NODES*MAX_STATIONS];
    bit trace_loaded [MAX_STATIONS*MAX_SAMPLES];
    int seed_pos [SEED_DEPTH+1];
    int cell_lo [SEED_DEPTH+1];
    int cell_hi [SEED_DEPTH+1];
    int seed_num;
    int win_half;
    logic [NCNT_W-1:0] reg_nodes;
    logic [SCNT_W-1:0] reg_stations;
    logic [KCNT_W-1:0] reg_samples;

    t_best best_q[$];
    int mismatches;
    int src_idle_pct;
    int snk_stall_pct;
    int hold_off;

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int nodes_used();
        return clamp(reg_nodes, 1, MAX_NODES);
    endfunction

    function automatic int stations_used();
        return clamp(reg_stations, 1, MAX_STATIONS);
    endfunction

    function automatic int samples_used();
        return clamp(reg_samples, 1, MAX_SAMPLES);
    endfunction

    function automatic void build_seeds();
        int n;
        int m;
        n = nodes_used();
        m = int'(int_root(4 * n));
        if (m < 1) m = 1;
        seed_num = m;
        for (int s = 0; s < m; s++) begin
            if (m == 1) seed_pos[s] = (n - 1) / 2;
            else seed_pos[s] = (2 * s * (n - 1) + (m - 1)) / (2 * (m - 1));
        end
        for (int s = 0; s < m; s++) begin
            cell_lo[s] = (s == 0) ? 0 : (seed_pos[s-1] + seed_pos[s]) / 2 + 1;
            cell_hi[s] = (s == m - 1) ? n - 1 : (seed_pos[s] + seed_pos[s+1]) / 2;
            if (cell_hi[s] > n - 1) cell_hi[s] = n - 1;
            if (cell_hi[s] < cell_lo[s]) cell_hi[s] = cell_lo[s];
        end
        win_half = (n + m) / (2 * m);
        if (win_half < 1) win_half = 1;
    endfunction

    function automatic int coherence(int nd, int k);
        longint sp = 0;
        longint ss = 0;
        int ns;
        int nsamp;
        int ip;
        int is;
        longint unsigned q;
        ns = stations_used();
        nsamp = samples_used();
        for (int j = 0; j < ns; j++) begin
            ip = p_shift[nd*MAX_STATIONS+j] + k;
            is = s_shift[nd*MAX_STATIONS+j] + k;
            if (ip < nsamp) sp += longint'($signed(p_trace[j*MAX_SAMPLES+ip]));
            if (is < nsamp) ss += longint'($signed(s_trace[j*MAX_SAMPLES+is]));
        end
        if (!((sp > 0 && ss > 0) || (sp < 0 && ss < 0))) return 0;
        if (sp < 0) sp = -sp;
        if (ss < 0) ss = -ss;
        q = int_root(longint'(sp * ss)) / ns;
        return q > SCORE_MAX ? SCORE_MAX : int'(q);
    endfunction

    function automatic t_best search(int k);
        int top_sc [TOP_COUNT_DEF];
        int top_sd [TOP_COUNT_DEF];
        int fill = 0;
        int best = 0;
        int best_i = 0;
        int v;
        int t;
        int u;
        int i0;
        int i1;
        t_best r;
        for (int s = 0; s < seed_num; s++) begin
            v = coherence(seed_pos[s], k);
            if (v > best) begin
                best = v;
                best_i = seed_pos[s];
            end
            t = 0;
            while (t < fill && !(v > top_sc[t])) t++;
            if (t < TOP_COUNT_DEF) begin
                u = (fill < TOP_COUNT_DEF) ? fill : TOP_COUNT_DEF - 1;
                for (; u > t; u--) begin
                    top_sc[u] = top_sc[u-1];
                    top_sd[u] = top_sd[u-1];
                end
                top_sc[t] = v;
                top_sd[t] = s;
                if (fill < TOP_COUNT_DEF) fill++;
            end
        end
        for (int w = 0; w < fill; w++) begin
            i0 = seed_pos[top_sd[w]] - win_half;
            i1 = seed_pos[top_sd[w]] + win_half;
            if (i0 < cell_lo[top_sd[w]]) i0 = cell_lo[top_sd[w]];
            if (i1 > cell_hi[top_sd[w]]) i1 = cell_hi[top_sd[w]];
            if (i1 > nodes_used() - 1) i1 = nodes_used() - 1;
            for (int i = i0; i <= i1; i++) begin
                v = coherence(i, k);
                if (v > best) begin
                    best = v;
                    best_i = i;
                end
            end
        end
        r.value = best[SCORE_W-1:0];
        r.node = best_i[NODE_W-1:0];
        return r;
    endfunction

    function automatic void apply_word(t_word w);
        case (w.func)
            FUNC_LOAD_SHIFT: begin
                p_shift[w.node*MAX_STATIONS+w.station] = w.p_tt;
                s_shift[w.node*MAX_STATIONS+w.station] = w.s_tt;
                shift_loaded[w.node*MAX_STATIONS+w.station] = 1;
            end
            FUNC_LOAD_TRACE: begin
                p_trace[w.station*MAX_SAMPLES+w.sample_index] = w.p_val;
                s_trace[w.station*MAX_SAMPLES+w.sample_index] = w.s_val;
                trace_loaded[w.station*MAX_SAMPLES+w.sample_index] = 1;
            end
            FUNC_COMPUTE: best_q.push_back(search(w.sample_index));
            default: ;
        endcase
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end

    // receiver side
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            result_if.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            result_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_best exp_r;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (best_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word value=%0d node=%0d",
                             result_if.best_value, result_if.best_node);
            end else begin
                exp_r = best_q.pop_front();
                if (result_if.best_value !== exp_r.value || result_if.best_node !== exp_r.node) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value=%0d node=%0d, got value=%0d node=%0d",
                                 exp_r.value, exp_r.node,
                                 result_if.best_value, result_if.best_node);
                end
            end
        end
    end

    task automatic send_word(t_word w);
        if ($urandom_range(99) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.func <= w.func;
        item_if.node <= w.node;
        item_if.station <= w.station;
        item_if.sample_index <= w.sample_index;
        item_if.p_travel_time <= w.p_tt;
        item_if.s_travel_time <= w.s_tt;
        item_if.p_value <= w.p_val;
        item_if.s_value <= w.s_val;
        do @(posedge i_clk); while (!item_if.ready);
        apply_word(w);
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (best_q.size() != 0 || hold_off > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, int value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_NODE_COUNT: begin
                reg_nodes = value[NCNT_W-1:0];
                build_seeds();
            end
            CFG_STATION_COUNT: reg_stations = value[SCNT_W-1:0];
            CFG_SAMPLE_COUNT: reg_samples = value[KCNT_W-1:0];
            default: ;
        endcase
    endtask

    function automatic t_word make_word(t_func f, int nd, int st, int idx);
        t_word w;
        int ns;
        ns = samples_used();
        w.func = f;
        w.node = nd[NODE_W-1:0];
        w.station = st[STA_W-1:0];
        w.sample_index = idx[SAMP_W-1:0];
        w.p_tt = ($urandom_range(9) == 0) ? SAMP_W'($urandom_range(4095))
                                          : SAMP_W'($urandom_range(ns - 1));
        w.s_tt = ($urandom_range(9) == 0) ? SAMP_W'($urandom_range(4095))
                                          : SAMP_W'($urandom_range(ns - 1));
        w.p_val = ($urandom_range(3) == 0) ? VAL_W'($urandom()) : VAL_W'($urandom_range(2000));
        w.s_val = ($urandom_range(3) == 0) ? VAL_W'($urandom()) : VAL_W'($urandom_range(2000));
        return w;
    endfunction

    // make sure every entry a search can read has been loaded
    task automatic fill_stores();
        for (int nd = 0; nd < nodes_used(); nd++)
            for (int st = 0; st < stations_used(); st++)
                if (!shift_loaded[nd*MAX_STATIONS+st])
                    send_word(make_word(FUNC_LOAD_SHIFT, nd, st, 0));
        for (int st = 0; st < stations_used(); st++)
            for (int k = 0; k < samples_used(); k++)
                if (!trace_loaded[st*MAX_SAMPLES+k])
                    send_word(make_word(FUNC_LOAD_TRACE, 0, st, k));
    endtask

    task automatic send_compute(int k);
        send_word(make_word(FUNC_COMPUTE, 0, 0, k));
    endtask

    task automatic test_directed();
        t_word w;
        write_reg(CFG_NODE_COUNT, 1);
        write_reg(CFG_STATION_COUNT, 1);
        write_reg(CFG_SAMPLE_COUNT, 1);
        w = make_word(FUNC_LOAD_SHIFT, 0, 0, 0);
        w.p_tt = 0;
        w.s_tt = 0;
        send_word(w);
        w = make_word(FUNC_LOAD_TRACE, 0, 0, 0);
        w.p_val = 16'h8000;
        w.s_val = 16'h8000;
        send_word(w);
        send_compute(0);
        w.p_val = 16'h7fff;
        w.s_val = 16'h7fff;
        send_word(w);
        send_compute(0);
        w.s_val = 16'h8000;
        send_word(w);
        send_compute(0);
        send_compute(4095);
        w.func = FUNC_NONE;
        send_word(w);
        w = make_word(FUNC_LOAD_SHIFT, 4095, 31, 4095);
        w.p_tt = 12'hfff;
        w.s_tt = 12'hfff;
        send_word(w);
        w = make_word(FUNC_LOAD_TRACE, 4095, 31, 4095);
        w.p_val = 16'hffff;
        w.s_val = 16'h7fff;
        send_word(w);
        w = make_word(FUNC_LOAD_TRACE, 0, 0, 0);
        w.p_val = 16'h0100;
        w.s_val = 16'h0400;
        send_word(w);
        write_reg(CFG_NODE_COUNT, 0);
        write_reg(CFG_STATION_COUNT, 0);
        write_reg(CFG_SAMPLE_COUNT, 0);
        send_compute(0);
        drain();
    endtask

    task automatic test_random(int n, int ns, int nsamp, int count, int computes_pct);
        int r;
        write_reg(CFG_NODE_COUNT, n);
        write_reg(CFG_STATION_COUNT, ns);
        write_reg(CFG_SAMPLE_COUNT, nsamp);
        fill_stores();
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < computes_pct)
                send_compute(($urandom_range(7) == 0) ? $urandom_range(4095)
                                                      : $urandom_range(samples_used() - 1));
            else if (r < computes_pct + 45)
                send_word(make_word(FUNC_LOAD_SHIFT, $urandom_range(nodes_used() - 1),
                                    $urandom_range(stations_used() - 1), 0));
            else if (r < 95)
                send_word(make_word(FUNC_LOAD_TRACE, 0, $urandom_range(stations_used() - 1),
                                    $urandom_range(samples_used() - 1)));
            else if (r < 98)
                send_word(make_word(FUNC_LOAD_TRACE, 0, $urandom_range(31), $urandom_range(4095)));
            else
                send_word(make_word(FUNC_NONE, $urandom(), $urandom(), $urandom()));
        end
        drain();
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        @(posedge i_clk);
        hold_off = 3000;
        for (int i = 0; i < 8; i++) send_compute($urandom_range(samples_used() - 1));
        drain();
    endtask

    task automatic test_pause();
        src_idle_pct = 20;
        snk_stall_pct = 20;
        for (int i = 0; i < 3; i++) send_compute($urandom_range(samples_used() - 1));
        drain();
        for (int i = 0; i < 3; i++) send_compute($urandom_range(samples_used() - 1));
        drain();
    endtask

    initial begin
        mismatches = 0;
        hold_off = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_NODE_COUNT;
        i_cfg_data = '0;
        item_if.valid = 1'b0;
        item_if.func = FUNC_NONE;
        item_if.node = '0;
        item_if.station = '0;
        item_if.sample_index = '0;
        item_if.p_travel_time = '0;
        item_if.s_travel_time = '0;
        item_if.p_value = '0;
        item_if.s_value = '0;
        result_if.ready = 1'b1;
        reg_nodes = MAX_NODES;
        reg_stations = MAX_STATIONS;
        reg_samples = MAX_SAMPLES;
        build_seeds();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(4, 2, 4, 12, 25);
        src_idle_pct = 68;
        test_random(6, 2, 5, 10, 25);
        src_idle_pct = 0;
        snk_stall_pct = 68;
        test_random(7, 2, 6, 10, 25);
        src_idle_pct = 37;
        snk_stall_pct = 37;
        test_random(9, 2, 6, 10, 25);
        test_backpressure();
        test_pause();

        drain();
        if (mismatches == 0 && best_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
